// File: rtl/gptq_pkg.sv
// ----------------------------------------------------------------------------
// gptq_pkg
// Shared types and codes for the ternary quantizer: request kinds, register
// indexes, sequencer states and the control bundle of the arithmetic unit.
// ----------------------------------------------------------------------------
package gptq_pkg;

  localparam logic [1:0] REQ_WR_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_WR_HINV   = 2'd1;
  localparam logic [1:0] REQ_RUN       = 2'd2;
  localparam logic [1:0] REQ_RD_CODE   = 2'd3;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  localparam int FRAC = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDCODE,
    ST_COL,
    ST_DIAG,
    ST_ROW,
    ST_QNT,
    ST_DIV,
    ST_UPD,
    ST_MULS,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_ctl_t;

endpackage

// File: rtl/gptq_ternary_quantizer.sv
// ----------------------------------------------------------------------------
// gptq_ternary_quantizer
// Ternary weight quantizer with error feedback over an inverse Hessian.
// ----------------------------------------------------------------------------
// Items arrive on the s_ group: tuser is the request kind, tdata the row,
// column and value. Every item gives one result item on the m_ group
// (code and status). A run item sweeps the columns in use: per column it
// reads the diagonal, per row it quantizes and divides in the shared unit,
// and, when the error is nonzero, multiplies and updates each later column
// of that row in the same unit; then it closes the sweep.
// s_tready is low while an item is in work.
// The result sits in an output register; a new item is taken while it
// waits only if m_tready takes it in the same cycle.
// Reset (rst, synchronous) restores the registers and clears the output;
// the stores are undefined until written.
// Registers over APB: alpha_scale at 0x0, rows_in_use at 0x4,
// cols_in_use at 0x8.
// ----------------------------------------------------------------------------
module gptq_ternary_quantizer #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // row_index[5:0], col_index[11:6], value[43:12]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // code[1:0], status[2]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gptq_pkg::*;

  localparam int V    = VALUE_BITS;
  localparam int NW   = V + 17;
  localparam int SW   = ((V > 33) ? V : 33) + 3;
  localparam int WD   = MAX_ROWS * MAX_COLS;
  localparam int HD   = MAX_COLS * MAX_COLS;
  localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
  localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
  localparam int RNW  = $clog2(MAX_ROWS + 1);
  localparam int CNW  = $clog2(MAX_COLS + 1);
  localparam int MW   = 2 * V - 15;
  localparam logic signed [SW-1:0] VMAX = {{(SW-V+1){1'b0}}, {(V-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = ~VMAX;

  function automatic logic signed [V-1:0] sat_v(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    y = (x > VMAX) ? VMAX : ((x < VMIN) ? VMIN : x);
    return y[V-1:0];
  endfunction

  function automatic logic [V-1:0] mag_v(input logic signed [V-1:0] x);
    return x[V-1] ? V'(-x) : V'(x);
  endfunction

  // registers
  logic [30:0] alpha_scale;
  logic [6:0]  rows_in_use;
  logic [6:0]  cols_in_use;

  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scale <= 31'd65536;
      rows_in_use <= 7'd64;
      cols_in_use <= 7'd64;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ALPHA: alpha_scale <= pwdata[30:0];
        REG_ROWS:  rows_in_use <= pwdata[6:0];
        REG_COLS:  cols_in_use <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = {1'b0, alpha_scale};
      REG_ROWS:  prdata = {25'd0, rows_in_use};
      REG_COLS:  prdata = {25'd0, cols_in_use};
      default:   prdata = '0;
    endcase
  end

  logic [RNW-1:0] nr;
  logic [CNW-1:0] nc;
  assign nr = (int'(rows_in_use) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(rows_in_use);
  assign nc = (int'(cols_in_use) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_in_use);

  // input item fields
  logic [1:0]         req_type;
  logic [5:0]         row_index;
  logic [5:0]         col_index;
  logic signed [31:0] value;
  assign row_index = s_tdata[5:0];
  assign col_index = s_tdata[11:6];
  assign value     = s_tdata[43:12];
  assign req_type  = s_tuser;

  logic accept;
  logic row_ok, col_ok, hrow_ok;
  assign accept  = s_tvalid && s_tready;
  assign row_ok  = int'(row_index) < int'(nr);
  assign col_ok  = int'(col_index) < int'(nc);
  assign hrow_ok = int'(row_index) < int'(nc);

  // sequencer
  state_t state, state_next;
  logic [CNW-1:0] c_cnt, j_cnt;
  logic [RNW-1:0] r_cnt;
  logic signed [V-1:0] d_reg, wj_reg, err_reg;
  logic           err_neg;
  logic           mdu_b_neg;

  logic           m_valid;
  logic [1:0]     m_code;
  logic           m_status;

  assign s_tready = (state == ST_IDLE) && (!m_valid || m_tready);
  assign m_tvalid = m_valid;
  assign m_tdata  = {5'd0, m_status, m_code};

  // memories
  logic signed [V-1:0] weight_mem [WD];
  logic signed [V-1:0] hinv_mem [HD];
  logic [1:0]          code_mem [WD];
  logic [WAW-1:0] w_raddr, w_waddr, code_waddr, code_raddr;
  logic [HAW-1:0] h_raddr, h_waddr;
  logic signed [V-1:0] w_wdata, h_wdata, w_rdata, h_rdata;
  logic [1:0]     code_wdata, code_rdata;
  logic           w_we, h_we, code_we;

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_waddr] <= w_wdata;
    w_rdata <= weight_mem[w_raddr];
  end
  always_ff @(posedge clk) begin
    if (h_we) hinv_mem[h_waddr] <= h_wdata;
    h_rdata <= hinv_mem[h_raddr];
  end
  always_ff @(posedge clk) begin
    if (code_we) code_mem[code_waddr] <= code_wdata;
    code_rdata <= code_mem[code_raddr];
  end

  // quantize and error numerator
  logic signed [SW-1:0] w2, alpha_s, diff;
  logic signed [V-1:0]  num, dden;
  logic [1:0]           qcode;
  logic                 div_neg;
  logic [V-1:0]         md;
  always_comb begin
    w2      = SW'(w_rdata) <<< 1;
    alpha_s = SW'({1'b0, alpha_scale});
    if (w2 > alpha_s) begin
      qcode = 2'b01;
      diff  = SW'(w_rdata) - alpha_s;
    end else if (w2 < -alpha_s) begin
      qcode = 2'b11;
      diff  = SW'(w_rdata) + alpha_s;
    end else begin
      qcode = 2'b00;
      diff  = SW'(w_rdata);
    end
    num     = sat_v(diff);
    dden    = (d_reg == '0) ? V'(1) : d_reg;
    div_neg = num[V-1] ^ dden[V-1];
    md      = mag_v(dden);
  end

  // shared unit
  mdu_ctl_t        mdu_ctl;
  logic [NW-1:0]   mdu_a;
  logic [V-1:0]    mdu_b;
  logic            mdu_done;
  logic [2*V-1:0]  mdu_prod;
  logic [NW-1:0]   mdu_quo;

  gptq_mdu #(.VB(V)) u_mdu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mdu_ctl),
    .op_a (mdu_a),
    .op_b (mdu_b),
    .done (mdu_done),
    .prod (mdu_prod),
    .quo  (mdu_quo)
  );

  // quotient saturation
  logic [NW-1:0]       qlim;
  logic [NW-1:0]       qmag;
  logic signed [V-1:0] err_val;
  always_comb begin
    qlim    = (NW'(1) << (V - 1)) - (err_neg ? NW'(0) : NW'(1));
    qmag    = (mdu_quo > qlim) ? qlim : mdu_quo;
    err_val = err_neg ? V'(-qmag) : V'(qmag);
  end

  // product rounding, saturation and weight update
  logic                mul_neg;
  logic [2*V:0]        prnd;
  logic [MW-1:0]       pmag, plim;
  logic signed [SW-1:0] p_s;
  logic signed [V-1:0] w_new;
  always_comb begin
    mul_neg = err_reg[V-1] ^ mdu_b_neg;
    prnd    = {1'b0, mdu_prod} + (2*V+1)'(1 << (FRAC - 1));
    plim    = (MW'(1) << (V - 1)) - (mul_neg ? MW'(0) : MW'(1));
    pmag    = (prnd[2*V:FRAC] > plim) ? plim : prnd[2*V:FRAC];
    p_s     = mul_neg ? -SW'(pmag) : SW'(pmag);
    w_new   = sat_v(SW'(wj_reg) - p_s);
  end

  function automatic logic [WAW-1:0] waddr(input int r, input int c);
    return WAW'(r * MAX_COLS + c);
  endfunction
  function automatic logic [HAW-1:0] haddr(input int r, input int c);
    return HAW'(r * MAX_COLS + c);
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) begin
                   if (req_type == REQ_RUN) state_next = ST_COL;
                   else if (req_type == REQ_RD_CODE && row_ok && col_ok)
                     state_next = ST_RDCODE;
                 end
      ST_RDCODE: state_next = ST_IDLE;
      ST_COL:    state_next = (c_cnt >= nc) ? ST_IDLE : ST_DIAG;
      ST_DIAG:   state_next = ST_ROW;
      ST_ROW:    state_next = (r_cnt >= nr) ? ST_COL : ST_QNT;
      ST_QNT:    state_next = ST_DIV;
      ST_DIV:    if (mdu_done) state_next = (err_val == '0) ? ST_ROW : ST_UPD;
      ST_UPD:    state_next = (j_cnt >= nc) ? ST_ROW : ST_MULS;
      ST_MULS:   state_next = ST_MUL;
      ST_MUL:    if (mdu_done) state_next = ST_UPD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    w_we       = 1'b0;
    h_we       = 1'b0;
    code_we    = 1'b0;
    w_waddr    = waddr(int'(row_index), int'(col_index));
    h_waddr    = haddr(int'(row_index), int'(col_index));
    w_wdata    = sat_v(SW'(value));
    h_wdata    = sat_v(SW'(value));
    code_raddr = waddr(int'(row_index), int'(col_index));
    code_waddr = waddr(int'(r_cnt), int'(c_cnt));
    code_wdata = qcode;
    w_raddr    = waddr(int'(r_cnt), int'(c_cnt));
    h_raddr    = haddr(int'(c_cnt), int'(c_cnt));
    mdu_ctl    = '0;
    mdu_a      = ({NW{1'b0}} | (NW'(mag_v(num)) << FRAC)) + NW'(md >> 1);
    mdu_b      = md;
    case (state)
      ST_IDLE: begin
        w_we = accept && req_type == REQ_WR_WEIGHT && row_ok && col_ok;
        h_we = accept && req_type == REQ_WR_HINV && hrow_ok && col_ok;
      end
      ST_QNT: begin
        code_we        = 1'b1;
        mdu_ctl.start  = 1'b1;
        mdu_ctl.is_div = 1'b1;
      end
      ST_UPD: begin
        w_raddr = waddr(int'(r_cnt), int'(j_cnt));
        h_raddr = haddr(int'(c_cnt), int'(j_cnt));
      end
      ST_MULS: begin
        mdu_ctl.start = 1'b1;
        mdu_a         = NW'(mag_v(err_reg));
        mdu_b         = mag_v(h_rdata);
      end
      ST_MUL: begin
        w_waddr = waddr(int'(r_cnt), int'(j_cnt));
        w_wdata = w_new;
        w_we    = mdu_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept && req_type != REQ_RUN && !(req_type == REQ_RD_CODE
          && row_ok && col_ok)) begin
        m_valid  <= 1'b1;
        m_code   <= 2'b00;
        m_status <= (req_type == REQ_WR_HINV) ? !(hrow_ok && col_ok) : !(row_ok && col_ok);
      end else if (state == ST_RDCODE) begin
        m_valid  <= 1'b1;
        m_code   <= code_rdata;
        m_status <= 1'b0;
      end else if (state == ST_COL && c_cnt >= nc) begin
        m_valid  <= 1'b1;
        m_code   <= 2'b00;
        m_status <= 1'b0;
      end else if (m_valid && m_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: c_cnt <= '0;
      ST_DIAG: begin
        d_reg <= h_rdata;
        r_cnt <= '0;
      end
      ST_ROW: if (r_cnt >= nr) c_cnt <= c_cnt + 1'b1;
      ST_QNT: begin
        err_neg <= div_neg;
      end
      ST_DIV: if (mdu_done) begin
        err_reg <= err_val;
        j_cnt   <= c_cnt + 1'b1;
        if (err_val == '0) r_cnt <= r_cnt + 1'b1;
      end
      ST_UPD: if (j_cnt >= nc) r_cnt <= r_cnt + 1'b1;
      ST_MULS: begin
        wj_reg    <= w_rdata;
        mdu_b_neg <= h_rdata[V-1];
      end
      ST_MUL: if (mdu_done) j_cnt <= j_cnt + 1'b1;
      default: ;
    endcase
  end
endmodule

// File: rtl/gptq_mdu.sv
// ----------------------------------------------------------------------------
// gptq_mdu
// Shared iterative unit: unsigned shift-add multiply (one bit per cycle) or
// restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module gptq_mdu #(
  parameter int VB = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gptq_pkg::mdu_ctl_t     ctl,
  input  logic [VB+16:0]         op_a,
  input  logic [VB-1:0]          op_b,
  output logic                   done,
  output logic [2*VB-1:0]        prod,
  output logic [VB+16:0]         quo
);
  import gptq_pkg::*;

  localparam int NW = VB + 17;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          is_div;
  logic [CW-1:0] cnt;
  logic [VB-1:0] mcand;
  logic [VB-1:0] rem;
  logic [VB:0]   psum;
  logic [VB:0]   trial;
  logic          fits;

  always_comb begin
    psum  = {1'b0, prod[2*VB-1:VB]} + (prod[0] ? {1'b0, mcand} : '0);
    trial = {rem, quo[NW-1]};
    fits  = trial >= {1'b0, mcand};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy   <= 1'b1;
        is_div <= ctl.is_div;
        cnt    <= ctl.is_div ? CW'(NW) : CW'(VB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand <= op_b;
      if (ctl.is_div) begin
        quo <= op_a;
        rem <= '0;
      end else begin
        prod <= {{VB{1'b0}}, op_a[VB-1:0]};
      end
    end else if (busy) begin
      if (is_div) begin
        rem <= fits ? VB'(trial - {1'b0, mcand}) : trial[VB-1:0];
        quo <= {quo[NW-2:0], fits};
      end else begin
        prod <= {psum, prod[VB-1:1]};
      end
    end
  end
endmodule

// File: rtl/gptq_checker.sv
// ----------------------------------------------------------------------------
// gptq_checker
// Port-level checks on the ternary quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module gptq_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import gptq_pkg::*;

  // a pending result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // no new item while the output register is full and not drained
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tready)
    else $error("item taken over a pending result");

  // write items answer in the next cycle with a zero code
  a_write_resp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_WR_WEIGHT || s_tuser == REQ_WR_HINV)
    |=> m_tvalid && m_tdata[1:0] == 2'b00)
    else $error("write item without result");

  // a run item keeps the input side closed in the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_RUN |=> !s_tready)
    else $error("input open during sweep");
endmodule

bind gptq_ternary_quantizer gptq_checker u_gptq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ternary quantizer: loads weights and inverse
// Hessian, runs column sweeps at several register settings and reads codes
// back, predicting every result item in a local model of the sweep.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gptq_pkg::*;

  localparam int  DIM   = 64;
  localparam int  LIMIT = 10000000;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
  } req_t;

  typedef struct {
    logic [1:0] code;
    logic       status;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // row[5:0], col[11:6], value[43:12]
  logic [1:0]  s_tuser = '0;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // code[1:0], status[2]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gptq_ternary_quantizer dut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint     weights [DIM*DIM];
  longint     hinv    [DIM*DIM];
  logic [1:0] codes   [DIM*DIM];
  longint     alpha = 65536;
  int         n_rows = 64;
  int         n_cols = 64;

  // what the stimulus has written so far
  bit w_done [DIM*DIM];
  bit h_done [DIM*DIM];
  bit c_done [DIM*DIM];

  req_t    pending_items[$];
  answer_t expected_answers[$];
  req_t    cur;
  int      errors = 0;
  int      cycles = 0;
  int      checked = 0;
  int      hold_cycles = 0;
  bit      held = 1'b0;
  bit      steady = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic longint sat32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sat_mag(input bit neg, input longint unsigned m);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    longint unsigned ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    return sat_mag((a < 0) != (b < 0), (ma * mb + 64'd32768) >> FRAC);
  endfunction

  function automatic longint q_div(input longint n, input longint d);
    longint unsigned mn, md;
    if (d == 0) d = 1;
    mn = (n < 0 ? -n : n) << FRAC;
    md = d < 0 ? -d : d;
    return sat_mag((n < 0) != (d < 0), (mn + (md >> 1)) / md);
  endfunction

  function automatic void sweep_columns();
    longint w, q, err, d;
    logic [1:0] code;
    for (int c = 0; c < n_cols; c++) begin
      d = hinv[c*DIM + c];
      for (int r = 0; r < n_rows; r++) begin
        w = weights[r*DIM + c];
        if (2*w > alpha) begin
          q = alpha; code = 2'b01;
        end else if (2*w < -alpha) begin
          q = -alpha; code = 2'b11;
        end else begin
          q = 0; code = 2'b00;
        end
        codes[r*DIM + c] = code;
        err = q_div(sat32(w - q), d);
        if (err != 0)
          for (int j = c + 1; j < n_cols; j++)
            weights[r*DIM + j] = sat32(weights[r*DIM + j] - q_mul(err, hinv[c*DIM + j]));
      end
    end
  endfunction

  function automatic void predict_answer(input req_t it);
    answer_t a;
    longint v;
    int idx;
    a.code = 2'b00;
    a.status = 1'b0;
    v = longint'(signed'(it.value));
    idx = it.row * DIM + it.col;
    case (it.kind)
      REQ_RUN: sweep_columns();
      REQ_WR_HINV: begin
        if (it.row < n_cols && it.col < n_cols) hinv[idx] = v;
        else a.status = 1'b1;
      end
      default: begin
        if (it.row < n_rows && it.col < n_cols) begin
          if (it.kind == REQ_WR_WEIGHT) weights[idx] = v;
          else a.code = codes[idx];
        end else begin
          a.status = 1'b1;
        end
      end
    endcase
    expected_answers.push_back(a);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid && s_tready) begin
        predict_answer(cur);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
        cur = pending_items[0];
        s_tvalid <= 1'b1;
        s_tuser  <= cur.kind;
        s_tdata  <= {4'b0, cur.value, cur.col, cur.row};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        checked++;
        if (expected_answers.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          e = expected_answers.pop_front();
          if (m_tdata[1:0] !== e.code)
            report($sformatf("code %b, expected %b", m_tdata[1:0], e.code));
          if (m_tdata[2] !== e.status)
            report($sformatf("status %b, expected %b", m_tdata[2], e.status));
        end
      end
      // one long hold-off so the block backs up its input
      if (!held && checked == 300) begin
        held = 1'b1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || $urandom_range(99) >= 15;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ALPHA: alpha = val[30:0];
      REG_ROWS:  n_rows = val[6:0] > 64 ? 64 : val[6:0];
      REG_COLS:  n_cols = val[6:0] > 64 ? 64 : val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_answers.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push(input logic [1:0] k, input int r, input int c, input logic [31:0] v);
    req_t it;
    int idx;
    it.kind = k; it.row = r; it.col = c; it.value = v;
    idx = r * DIM + c;
    if (k == REQ_WR_WEIGHT && r < n_rows && c < n_cols) w_done[idx] = 1'b1;
    if (k == REQ_WR_HINV && r < n_cols && c < n_cols) h_done[idx] = 1'b1;
    if (k == REQ_RUN)
      for (int i = 0; i < n_rows; i++)
        for (int j = 0; j < n_cols; j++) c_done[i*DIM + j] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_value(input bit diag);
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return diag ? 32'h0 : $urandom;
      default: begin
        if (diag) return $urandom_range(1) ? $urandom_range(1<<14, 1<<18)
                                           : -$urandom_range(1<<14, 1<<18);
        return $urandom_range(0, 1<<19) - (1<<18);
      end
    endcase
  endfunction

  task automatic start_run();
    for (int r = 0; r < n_rows; r++)
      for (int c = 0; c < n_cols; c++)
        if (!w_done[r*DIM + c]) push(REQ_WR_WEIGHT, r, c, rand_value(1'b0));
    for (int r = 0; r < n_cols; r++)
      for (int c = 0; c < n_cols; c++)
        if (!h_done[r*DIM + c]) push(REQ_WR_HINV, r, c, rand_value(r == c));
    push(REQ_RUN, $urandom_range(63), $urandom_range(63), $urandom);
  endtask

  task automatic random_phase(input logic [31:0] a, input int rows, input int cols,
                              input int n, input bit runs);
    int r, c, pick;
    drain();
    reg_write(REG_ALPHA, a);
    reg_write(REG_ROWS, rows);
    reg_write(REG_COLS, cols);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(4) == 0) begin
        r = $urandom_range(63); c = $urandom_range(63);
      end else begin
        r = $urandom_range(n_rows - 1); c = $urandom_range(n_cols - 1);
      end
      if (pick < 30) begin
        push(REQ_WR_WEIGHT, r, c, rand_value(1'b0));
      end else if (pick < 50) begin
        if (r >= n_cols && $urandom_range(3) != 0) r = $urandom_range(n_cols - 1);
        push(REQ_WR_HINV, r, c, rand_value(r == c));
      end else if (pick < 96 || !runs) begin
        // never read a code that no sweep has produced
        if (r < n_rows && c < n_cols && !c_done[r*DIM + c])
          push(REQ_WR_WEIGHT, r, c, rand_value(1'b0));
        else
          push(REQ_RD_CODE, r, c, $urandom);
      end else begin
        start_run();
      end
    end
    if (runs) begin
      start_run();
      for (int i = 0; i < 8; i++)
        push(REQ_RD_CODE, $urandom_range(n_rows - 1), $urandom_range(n_cols - 1), '0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: saturating extremes, an exact half-alpha tie, zero divisor,
    // every request kind and out-of-range indices
    reg_write(REG_ROWS, 2);
    reg_write(REG_COLS, 2);
    push(REQ_WR_WEIGHT, 0, 0, 32'h7fff_ffff);
    push(REQ_WR_WEIGHT, 0, 1, 32'h8000_0000);
    push(REQ_WR_WEIGHT, 1, 0, 32'd32768);
    push(REQ_WR_WEIGHT, 1, 1, -32'sd32769);
    push(REQ_WR_HINV, 0, 0, 32'h0);
    push(REQ_WR_HINV, 0, 1, 32'h7fff_ffff);
    push(REQ_WR_HINV, 1, 0, 32'h8000_0000);
    push(REQ_WR_HINV, 1, 1, 32'd65536);
    push(REQ_RUN, 0, 0, 32'h0);
    for (int i = 0; i < 4; i++) push(REQ_RD_CODE, i / 2, i % 2, 32'hffff_ffff);
    push(REQ_WR_WEIGHT, 2, 0, 32'h1234);
    push(REQ_WR_WEIGHT, 0, 63, 32'h1234);
    push(REQ_WR_HINV, 0, 2, 32'h1);
    push(REQ_WR_HINV, 63, 0, 32'h1);
    push(REQ_RD_CODE, 63, 63, 32'h0);
    push(REQ_RD_CODE, 1, 2, 32'h0);

    random_phase(32'd65536, 64, 64, 60, 1'b0);
    @(negedge clk) steady = 1'b1;
    random_phase(32'h7fff_ffff, 1, 1, 80, 1'b1);
    @(negedge clk) steady = 1'b0;
    random_phase(32'd0, 16, 4, 100, 1'b1);
    random_phase(32'd65536, 8, 8, 150, 1'b1);
    random_phase(32'd131072, 1, 8, 80, 1'b1);
    for (int k = 0; k < 4; k++)
      random_phase($urandom_range(0, 1<<19), $urandom_range(1, 12),
                   $urandom_range(1, 12), 90, 1'b1);
    random_phase(32'd65536, 1, 64, 60, 1'b0);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
